// File: design/cshk_pkg.sv
package cshk_pkg;

   localparam int MAX_ITEMS_DEFAULT = 32;
   localparam int DATA_W            = 32;
   localparam int CMP_W             = 11;
   localparam int ACC_W             = 11;
   localparam int SWP_W             = 10;

   // csr byte address: bit 2 picks the register, so one word past the list decodes too
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   typedef enum logic [0:0] {
      CSR_SIGNED_ORDER = 1'b0
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FWD_PRIME,
      ST_FWD_LOAD,
      ST_FWD_STEP,
      ST_FWD_FLUSH,
      ST_BWD_PRIME,
      ST_BWD_LOAD,
      ST_BWD_STEP,
      ST_BWD_FLUSH,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic clear;
      logic pass;
      logic step;
      logic swap;
   } cnt_ctrl_type;

endpackage

// File: design/cshk_store.sv
module cshk_store #(
   parameter int DEPTH = cshk_pkg::MAX_ITEMS_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [cshk_pkg::DATA_W-1:0] wr_data,
   input  logic [AW-1:0]               rd_addr,
   output logic [cshk_pkg::DATA_W-1:0] rd_data
);

   logic [cshk_pkg::DATA_W-1:0] mem [DEPTH];
   logic [cshk_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/cshk_cmp.sv
module cshk_cmp (
   input  logic                        signed_order,
   input  logic [cshk_pkg::DATA_W-1:0] op_a,
   input  logic [cshk_pkg::DATA_W-1:0] op_b,
   output logic                        gt,
   output logic [cshk_pkg::DATA_W-1:0] lo_val,
   output logic [cshk_pkg::DATA_W-1:0] hi_val
);

   logic [cshk_pkg::DATA_W-1:0] key_a;
   logic [cshk_pkg::DATA_W-1:0] key_b;

   // two's complement order is unsigned order with the sign bit flipped
   always_comb begin
      key_a = op_a;
      key_b = op_b;
      key_a[cshk_pkg::DATA_W-1] = op_a[cshk_pkg::DATA_W-1] ^ signed_order;
      key_b[cshk_pkg::DATA_W-1] = op_b[cshk_pkg::DATA_W-1] ^ signed_order;
      gt     = key_a > key_b;
      lo_val = gt ? op_b : op_a;
      hi_val = gt ? op_a : op_b;
   end

endmodule

// File: design/cshk_counters.sv
module cshk_counters (
   input  logic                       clock,
   input  logic                       reset,
   input  cshk_pkg::cnt_ctrl_type     ctrl,
   output logic [cshk_pkg::CMP_W-1:0] comparisons,
   output logic [cshk_pkg::ACC_W-1:0] accesses,
   output logic [cshk_pkg::SWP_W-1:0] swaps
);

   localparam logic [cshk_pkg::CMP_W:0] CMP_CAP = {1'b0, {cshk_pkg::CMP_W{1'b1}}};
   localparam logic [cshk_pkg::ACC_W:0] ACC_CAP = {1'b0, {cshk_pkg::ACC_W{1'b1}}};
   localparam logic [cshk_pkg::SWP_W:0] SWP_CAP = {1'b0, {cshk_pkg::SWP_W{1'b1}}};

   logic [cshk_pkg::CMP_W-1:0] cmp_ff, cmp_in;
   logic [cshk_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [cshk_pkg::SWP_W-1:0] swp_ff, swp_in;
   logic [cshk_pkg::CMP_W:0]   cmp_sum;
   logic [cshk_pkg::ACC_W:0]   acc_sum;
   logic [cshk_pkg::SWP_W:0]   swp_sum;

   always_comb begin
      cmp_sum = {1'b0, cmp_ff};
      acc_sum = {1'b0, acc_ff};
      swp_sum = {1'b0, swp_ff};
      if (ctrl.pass) begin
         cmp_sum = cmp_sum + (cshk_pkg::CMP_W+1)'(1);
      end
      if (ctrl.step) begin
         cmp_sum = cmp_sum + (cshk_pkg::CMP_W+1)'(2);
         acc_sum = acc_sum + (cshk_pkg::ACC_W+1)'(2);
      end
      if (ctrl.swap) begin
         swp_sum = swp_sum + (cshk_pkg::SWP_W+1)'(1);
      end
      cmp_in = (cmp_sum > CMP_CAP) ? CMP_CAP[cshk_pkg::CMP_W-1:0] : cmp_sum[cshk_pkg::CMP_W-1:0];
      acc_in = (acc_sum > ACC_CAP) ? ACC_CAP[cshk_pkg::ACC_W-1:0] : acc_sum[cshk_pkg::ACC_W-1:0];
      swp_in = (swp_sum > SWP_CAP) ? SWP_CAP[cshk_pkg::SWP_W-1:0] : swp_sum[cshk_pkg::SWP_W-1:0];
      if (ctrl.clear) begin
         cmp_in = '0;
         acc_in = '0;
         swp_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_ff <= '0;
         acc_ff <= '0;
         swp_ff <= '0;
      end else begin
         cmp_ff <= cmp_in;
         acc_ff <= acc_in;
         swp_ff <= swp_in;
      end
   end

   assign comparisons = cmp_ff;
   assign accesses    = acc_ff;
   assign swaps       = swp_ff;

endmodule

// File: design/cocktail_shaker_sort_counted.sv
// Gathers up to MAX_ITEMS 32-bit words (one per start while busy is low) until a word
// marked last, sorts them in place with a cocktail shaker sort and then streams them
// out in ascending order, one word per cycle on rsp_strobe, each tagged with the final
// comparison, access and swap counts. There is no backpressure: every result is shown
// for exactly one cycle and must be taken then. A word without last leaves busy low.
// The sort runs on one storage RAM (one write and one registered read per cycle) and
// one shared comparator, one compare step per cycle: a pass runs through a prime state,
// a load, its compare steps and a flush of the carried word (a pass with no step ends
// at its prime state), and the sorted set is then streamed out. busy stays high from
// the last word until the final result is issued.
module cocktail_shaker_sort_counted #(
   parameter int MAX_ITEMS = cshk_pkg::MAX_ITEMS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [cshk_pkg::DATA_W-1:0] req_value,
   input  logic                        req_last,
   output logic                        rsp_strobe,
   output logic [cshk_pkg::DATA_W-1:0] rsp_sorted_value,
   output logic                        rsp_last_res,
   output logic [cshk_pkg::CMP_W-1:0]  rsp_comparisons,
   output logic [cshk_pkg::ACC_W-1:0]  rsp_accesses,
   output logic [cshk_pkg::SWP_W-1:0]  rsp_swaps,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [cshk_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [cshk_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [cshk_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);

   localparam int IW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam logic [CW-1:0] FULL = CW'(MAX_ITEMS);

   cshk_pkg::state_type         state_ff, state_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [CW-1:0]               round_ff, round_in;
   logic [IW-1:0]               pos_ff, pos_in;
   logic [IW-1:0]               emit_idx_ff, emit_idx_in;
   logic [cshk_pkg::DATA_W-1:0] carry_ff, carry_in;
   logic                        swapped_ff, swapped_in;
   logic                        strobe_ff, strobe_in;
   logic                        last_ff, last_in;
   logic                        signed_order_ff;

   logic                        wr_en;
   logic [IW-1:0]               wr_addr;
   logic [cshk_pkg::DATA_W-1:0] wr_data;
   logic [IW-1:0]               rd_addr;
   logic [cshk_pkg::DATA_W-1:0] rd_data;

   logic [cshk_pkg::DATA_W-1:0] op_a, op_b, lo_val, hi_val;
   logic                        gt;
   cshk_pkg::cnt_ctrl_type      cnt_ctrl;

   logic [CW:0]                 twice_r;
   logic                        fwd_ok, bwd_ok;
   logic [CW-1:0]               top_full;
   logic [IW-1:0]               lo_pos, top_pos, bwd_top;

   logic                        csr_wr;
   cshk_pkg::csr_index_type     csr_idx;

   // ---------------- config port ----------------
   assign csr_pready = 1'b1;
   assign csr_idx    = cshk_pkg::csr_index_type'(csr_paddr[cshk_pkg::CSR_AW-1:2]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      csr_prdata = '0;
      unique case (csr_idx)
         cshk_pkg::CSR_SIGNED_ORDER: csr_prdata[0] = signed_order_ff;
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         signed_order_ff <= 1'b1;
      end else if (csr_wr && csr_idx == cshk_pkg::CSR_SIGNED_ORDER) begin
         signed_order_ff <= csr_pwdata[0];
      end
   end

   // ---------------- datapath units ----------------
   cshk_store #(.DEPTH(MAX_ITEMS), .AW(IW)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // forward: carry sits at the lower slot; backward: at the upper slot
   assign op_a = (state_ff == cshk_pkg::ST_FWD_STEP) ? carry_ff : rd_data;
   assign op_b = (state_ff == cshk_pkg::ST_FWD_STEP) ? rd_data  : carry_ff;

   cshk_cmp u_cmp (
      .signed_order (signed_order_ff),
      .op_a         (op_a),
      .op_b         (op_b),
      .gt           (gt),
      .lo_val       (lo_val),
      .hi_val       (hi_val)
   );

   cshk_counters u_cnt (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (cnt_ctrl),
      .comparisons (rsp_comparisons),
      .accesses    (rsp_accesses),
      .swaps       (rsp_swaps)
   );

   // window of round r: [r, count-1-r]; backward pass stops one short of the top
   assign twice_r  = {round_ff, 1'b0};
   assign fwd_ok   = {1'b0, count_ff} > (twice_r + (CW+1)'(1));
   assign bwd_ok   = {1'b0, count_ff} > (twice_r + (CW+1)'(2));
   assign top_full = count_ff - round_ff - CW'(1);
   assign lo_pos   = round_ff[IW-1:0];
   assign top_pos  = top_full[IW-1:0];
   assign bwd_top  = top_pos - IW'(1);

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= cshk_pkg::ST_IDLE;
         count_ff    <= '0;
         round_ff    <= '0;
         emit_idx_ff <= '0;
         swapped_ff  <= 1'b0;
         strobe_ff   <= 1'b0;
         last_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         round_ff    <= round_in;
         emit_idx_ff <= emit_idx_in;
         swapped_ff  <= swapped_in;
         strobe_ff   <= strobe_in;
         last_ff     <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      carry_ff <= carry_in;
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      round_in    = round_ff;
      pos_in      = pos_ff;
      emit_idx_in = emit_idx_ff;
      carry_in    = carry_ff;
      swapped_in  = swapped_ff;
      strobe_in   = 1'b0;
      last_in     = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = pos_ff;
      wr_data     = lo_val;
      rd_addr     = pos_ff;
      cnt_ctrl    = '0;

      unique case (state_ff)
         cshk_pkg::ST_IDLE: begin
            if (start) begin
               // words past a full store are dropped
               if (count_ff < FULL) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[IW-1:0];
                  wr_data  = req_value;
                  count_in = count_ff + CW'(1);
               end
               if (req_last) begin
                  cnt_ctrl.clear = 1'b1;
                  round_in       = '0;
                  emit_idx_in    = '0;
                  state_in       = cshk_pkg::ST_FWD_PRIME;
               end
            end
         end
         cshk_pkg::ST_FWD_PRIME: begin
            cnt_ctrl.pass = 1'b1;
            swapped_in    = 1'b0;
            if (fwd_ok) begin
               rd_addr  = lo_pos;
               state_in = cshk_pkg::ST_FWD_LOAD;
            end else begin
               state_in = cshk_pkg::ST_EMIT;
            end
         end
         cshk_pkg::ST_FWD_LOAD: begin
            carry_in = rd_data;
            rd_addr  = lo_pos + IW'(1);
            pos_in   = lo_pos;
            state_in = cshk_pkg::ST_FWD_STEP;
         end
         cshk_pkg::ST_FWD_STEP: begin
            wr_en         = 1'b1;
            wr_addr       = pos_ff;
            wr_data       = lo_val;
            carry_in      = hi_val;
            cnt_ctrl.step = 1'b1;
            cnt_ctrl.swap = gt;
            if (gt) begin
               swapped_in = 1'b1;
            end
            if (pos_ff + IW'(1) == top_pos) begin
               state_in = cshk_pkg::ST_FWD_FLUSH;
            end else begin
               pos_in  = pos_ff + IW'(1);
               rd_addr = pos_ff + IW'(2);
            end
         end
         cshk_pkg::ST_FWD_FLUSH: begin
            wr_en    = 1'b1;
            wr_addr  = top_pos;
            wr_data  = carry_ff;
            state_in = swapped_ff ? cshk_pkg::ST_BWD_PRIME : cshk_pkg::ST_EMIT;
         end
         cshk_pkg::ST_BWD_PRIME: begin
            cnt_ctrl.pass = 1'b1;
            swapped_in    = 1'b0;
            if (bwd_ok) begin
               rd_addr  = bwd_top;
               state_in = cshk_pkg::ST_BWD_LOAD;
            end else begin
               state_in = cshk_pkg::ST_EMIT;
            end
         end
         cshk_pkg::ST_BWD_LOAD: begin
            carry_in = rd_data;
            rd_addr  = bwd_top - IW'(1);
            pos_in   = bwd_top;
            state_in = cshk_pkg::ST_BWD_STEP;
         end
         cshk_pkg::ST_BWD_STEP: begin
            wr_en         = 1'b1;
            wr_addr       = pos_ff;
            wr_data       = hi_val;
            carry_in      = lo_val;
            cnt_ctrl.step = 1'b1;
            cnt_ctrl.swap = gt;
            if (gt) begin
               swapped_in = 1'b1;
            end
            if (pos_ff - IW'(1) == lo_pos) begin
               state_in = cshk_pkg::ST_BWD_FLUSH;
            end else begin
               pos_in  = pos_ff - IW'(1);
               rd_addr = pos_ff - IW'(2);
            end
         end
         cshk_pkg::ST_BWD_FLUSH: begin
            wr_en   = 1'b1;
            wr_addr = lo_pos;
            wr_data = carry_ff;
            if (swapped_ff) begin
               round_in = round_ff + CW'(1);
               state_in = cshk_pkg::ST_FWD_PRIME;
            end else begin
               state_in = cshk_pkg::ST_EMIT;
            end
         end
         cshk_pkg::ST_EMIT: begin
            // read issued here, word shows on the ports next cycle
            rd_addr   = emit_idx_ff;
            strobe_in = 1'b1;
            if (CW'(emit_idx_ff) + CW'(1) == count_ff) begin
               last_in     = 1'b1;
               emit_idx_in = '0;
               count_in    = '0;
               round_in    = '0;
               state_in    = cshk_pkg::ST_IDLE;
            end else begin
               emit_idx_in = emit_idx_ff + IW'(1);
            end
         end
         default: begin
            state_in = cshk_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy             = (state_ff != cshk_pkg::ST_IDLE);
   assign rsp_strobe       = strobe_ff;
   assign rsp_last_res     = last_ff;
   assign rsp_sorted_value = rd_data;

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int DEPTH   = cshk_pkg::MAX_ITEMS_DEFAULT;
   localparam int CMP_CAP = (1 << cshk_pkg::CMP_W) - 1;
   localparam int ACC_CAP = (1 << cshk_pkg::ACC_W) - 1;
   localparam int SWP_CAP = (1 << cshk_pkg::SWP_W) - 1;
   localparam logic [cshk_pkg::CSR_AW-1:0] ORDER_ADDR  = {cshk_pkg::CSR_SIGNED_ORDER, 2'b00};
   localparam logic [cshk_pkg::CSR_AW-1:0] UNUSED_ADDR = ORDER_ADDR + 3'd4;
   localparam int SETTLE_CYCLES = 40;

   typedef struct {
      logic [cshk_pkg::DATA_W-1:0] value;
      logic                        last;
   } load_word_type;

   typedef struct {
      logic [cshk_pkg::DATA_W-1:0] value;
      logic                        last;
      logic [cshk_pkg::CMP_W-1:0]  cmp;
      logic [cshk_pkg::ACC_W-1:0]  acc;
      logic [cshk_pkg::SWP_W-1:0]  swp;
   } sorted_word_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic [cshk_pkg::DATA_W-1:0] req_value = '0;
   logic                        req_last = 1'b0;
   logic                        rsp_strobe;
   logic [cshk_pkg::DATA_W-1:0] rsp_sorted_value;
   logic                        rsp_last_res;
   logic [cshk_pkg::CMP_W-1:0]  rsp_comparisons;
   logic [cshk_pkg::ACC_W-1:0]  rsp_accesses;
   logic [cshk_pkg::SWP_W-1:0]  rsp_swaps;
   logic                        csr_psel = 1'b0;
   logic                        csr_penable = 1'b0;
   logic                        csr_pwrite = 1'b0;
   logic [cshk_pkg::CSR_AW-1:0] csr_paddr = '0;
   logic [cshk_pkg::CSR_DW-1:0] csr_pwdata = '0;
   logic [cshk_pkg::CSR_DW-1:0] csr_prdata;
   logic                        csr_pready;

   cocktail_shaker_sort_counted dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_value(req_value), .req_last(req_last),
      .rsp_strobe(rsp_strobe), .rsp_sorted_value(rsp_sorted_value),
      .rsp_last_res(rsp_last_res), .rsp_comparisons(rsp_comparisons),
      .rsp_accesses(rsp_accesses), .rsp_swaps(rsp_swaps),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   load_word_type   pending_words[$];
   sorted_word_type sorted_due[$];
   int              words_queued = 0;
   int              words_taken = 0;
   int              errors = 0;
   bit              word_taken = 1'b0;
   bit              steady = 1'b0;

   // sorter image
   logic [cshk_pkg::DATA_W-1:0] held_words[DEPTH];
   int                          held_count = 0;
   bit                          order_signed = 1'b1;
   int                          tally_cmp, tally_acc, tally_swp;

   task automatic note_mismatch(string what, longint got, longint want);
      errors++;
      $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
   endtask

   function automatic int bump(int c, int by, int cap);
      return (c + by > cap) ? cap : c + by;
   endfunction

   function automatic bit orders_after(logic [cshk_pkg::DATA_W-1:0] a,
                                       logic [cshk_pkg::DATA_W-1:0] b);
      return order_signed ? ($signed(a) > $signed(b)) : (a > b);
   endfunction

   function automatic void step_and_swap(int lo_idx, int hi_idx, ref bit clean);
      logic [cshk_pkg::DATA_W-1:0] t;
      tally_cmp = bump(tally_cmp, 2, CMP_CAP);
      tally_acc = bump(tally_acc, 2, ACC_CAP);
      if (orders_after(held_words[lo_idx], held_words[hi_idx])) begin
         t = held_words[lo_idx];
         held_words[lo_idx] = held_words[hi_idx];
         held_words[hi_idx] = t;
         tally_swp = bump(tally_swp, 1, SWP_CAP);
         clean = 1'b0;
      end
   endfunction

   function automatic bit sweep_up(int lo, int len);
      bit clean = 1'b1;
      tally_cmp = bump(tally_cmp, 1, CMP_CAP);
      for (int k = 0; k < len - 1; k++) step_and_swap(lo + k, lo + k + 1, clean);
      return clean;
   endfunction

   function automatic bit sweep_down(int lo, int len);
      bit clean = 1'b1;
      tally_cmp = bump(tally_cmp, 1, CMP_CAP);
      for (int k = len - 2; k > 0; k--) step_and_swap(lo + k - 1, lo + k, clean);
      return clean;
   endfunction

   function automatic void load_and_sort(load_word_type w);
      sorted_word_type r;
      int round = 0;
      int len;
      if (held_count < DEPTH) begin
         held_words[held_count] = w.value;
         held_count++;
      end
      if (!w.last) return;
      tally_cmp = 0;
      tally_acc = 0;
      tally_swp = 0;
      while (1) begin
         len = held_count - 2 * round;
         if (sweep_up(round, len)) break;
         if (sweep_down(round, len)) break;
         round++;
      end
      for (int k = 0; k < held_count; k++) begin
         r.value = held_words[k];
         r.last  = (k + 1 == held_count);
         r.cmp   = tally_cmp[cshk_pkg::CMP_W-1:0];
         r.acc   = tally_acc[cshk_pkg::ACC_W-1:0];
         r.swp   = tally_swp[cshk_pkg::SWP_W-1:0];
         sorted_due.push_back(r);
      end
      held_count = 0;
   endfunction

   // driver: next word goes out on the falling edge once the current one is taken
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || word_taken) begin
         if (pending_words.size() != 0 && (steady || $urandom_range(99) >= 8)) begin
            req_value <= pending_words[0].value;
            req_last  <= pending_words[0].last;
            pending_words.pop_front();
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      sorted_word_type e;
      load_word_type   w;
      word_taken = !reset && start && !busy;
      if (!reset && rsp_strobe) begin
         if (sorted_due.size() == 0) begin
            note_mismatch("unexpected word", rsp_sorted_value, 0);
         end else begin
            e = sorted_due.pop_front();
            if (rsp_sorted_value !== e.value) note_mismatch("sorted_value", rsp_sorted_value, e.value);
            if (rsp_last_res !== e.last) note_mismatch("last_res", rsp_last_res, e.last);
            if (rsp_comparisons !== e.cmp) note_mismatch("comparisons", rsp_comparisons, e.cmp);
            if (rsp_accesses !== e.acc) note_mismatch("accesses", rsp_accesses, e.acc);
            if (rsp_swaps !== e.swp) note_mismatch("swaps", rsp_swaps, e.swp);
         end
      end
      if (word_taken) begin
         w.value = req_value;
         w.last  = req_last;
         load_and_sort(w);
         words_taken++;
      end
   end

   task automatic push_word(logic [cshk_pkg::DATA_W-1:0] v, logic l);
      load_word_type w;
      w.value = v;
      w.last  = l;
      pending_words.push_back(w);
      words_queued++;
   endtask

   function automatic logic [cshk_pkg::DATA_W-1:0] pick_value();
      int small_v;
      case ($urandom_range(3))
         2: begin
            case ($urandom_range(6))
               0: return 32'h0000_0000;
               1: return 32'hFFFF_FFFF;
               2: return 32'h8000_0000;
               3: return 32'h7FFF_FFFF;
               4: return 32'h0000_0001;
               5: return 32'h8000_0001;
               default: return 32'hFFFF_FFFE;
            endcase
         end
         3: begin
            small_v = int'($urandom_range(15)) - 8;   // duplicates around zero
            return small_v;
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_set(int n);
      for (int i = 0; i < n; i++) push_word(pick_value(), i == n - 1);
   endtask

   task automatic drain();
      while (words_taken != words_queued || sorted_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic [cshk_pkg::CSR_AW-1:0] addr,
                            logic [cshk_pkg::CSR_DW-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if ((addr >> 2) == cshk_pkg::CSR_SIGNED_ORDER) order_signed = data[0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_check_order();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr   <= ORDER_ADDR;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== {{(cshk_pkg::CSR_DW - 1){1'b0}}, order_signed})
         note_mismatch("signed_order readback", csr_prdata, order_signed);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      int random_words = 0;
      int phase = 0;
      int phase_words;
      int n;
      int r;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // signed order straight out of reset
      csr_check_order();
      push_word(32'h7FFF_FFFF, 1'b0);
      push_word(32'h8000_0000, 1'b0);
      push_word(32'h0000_0000, 1'b0);
      push_word(32'hFFFF_FFFF, 1'b0);
      push_word(32'h0000_0001, 1'b1);
      push_word(32'h8000_0000, 1'b1);          // lone word: one empty pass
      for (int i = 5; i >= 1; i--) push_word(i, i == 1);
      for (int i = 1; i <= 3; i++) push_word(i, i == 3);
      push_word(32'd7, 1'b0);
      push_word(32'd7, 1'b1);
      drain();

      // unsigned; only bit 0 of the write counts
      csr_write(ORDER_ADDR, 32'hFFFF_FFFE);
      csr_check_order();
      push_word(32'h7FFF_FFFF, 1'b0);
      push_word(32'h8000_0000, 1'b0);
      push_word(32'h0000_0000, 1'b0);
      push_word(32'hFFFF_FFFF, 1'b0);
      push_word(32'h0000_0001, 1'b1);
      push_word(32'h0000_0000, 1'b1);
      drain();

      // write past the register list: must leave the order alone
      csr_write(UNUSED_ADDR, 32'hFFFF_FFFF);
      csr_check_order();

      while (random_words < 500) begin
         if (phase > 0) begin
            csr_write(ORDER_ADDR, ($urandom & ~32'h1) | (phase % 2));
            csr_check_order();
         end
         steady = (phase == 2);
         phase_words = 0;
         while (phase_words < 60) begin
            r = $urandom_range(99);
            if (r < 80) n = $urandom_range(8, 1);
            else if (r < 95) n = $urandom_range(20, 9);
            else n = $urandom_range(DEPTH + 4, DEPTH - 3);   // sizes near and past the store on purpose
            queue_set(n);
            phase_words += n;
         end
         random_words += phase_words;
         drain();
         phase++;
      end
      steady = 1'b0;

      if (sorted_due.size() != 0) note_mismatch("words left over", 0, sorted_due.size());
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
